[src/gbat_pkg.sv]
// shared constants, types and helpers of the group-by aggregation table
// no dependencies
package gbat_pkg;

  localparam int NUM_GROUPS = 64;
  localparam int MAX_SLOTS  = 4;
  localparam int GIDX_W     = $clog2(NUM_GROUPS);
  localparam int TOT_W      = $clog2(NUM_GROUPS + 1);
  localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 32;
  localparam int NCNT_W     = 3;
  localparam int FUNCS_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_AGG_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGG_FUNCS = 2'd1;

  localparam logic [2:0] FN_SUM   = 3'd0;
  localparam logic [2:0] FN_AVG   = 3'd1;
  localparam logic [2:0] FN_COUNT = 3'd2;
  localparam logic [2:0] FN_MIN   = 3'd3;
  localparam logic [2:0] FN_MAX   = 3'd4;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] mn;
    logic signed [VAL_W-1:0] mx;
    logic [CNT_W-1:0]        cnt;
  } slot_acc_t;

  typedef slot_acc_t [MAX_SLOTS-1:0] acc_row_t;

  typedef struct packed {
    logic                                is_flush;
    logic [KEY_W-1:0]                    key;
    logic [MAX_SLOTS-1:0][VAL_W-1:0]     val;
    logic [MAX_SLOTS-1:0]                present;
  } cmd_t;

  typedef struct packed {
    logic [NCNT_W-1:0]  n;
    logic [FUNCS_W-1:0] funcs;
  } cfg_t;

  // codes above max act as count
  function automatic logic [2:0] slot_func(input logic [FUNCS_W-1:0] funcs,
                                           input logic [SLOT_W-1:0] k);
    logic [2:0] f;
    f = funcs[3*k +: 3];
    return (f > FN_MAX) ? FN_COUNT : f;
  endfunction

endpackage

[src/gbat_if.sv]
// channel interfaces of the group-by aggregation table
// depends on gbat_pkg
interface gbat_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [gbat_pkg::KEY_W-1:0]    group_key;
  logic signed [gbat_pkg::VAL_W-1:0] value_0;
  logic signed [gbat_pkg::VAL_W-1:0] value_1;
  logic signed [gbat_pkg::VAL_W-1:0] value_2;
  logic signed [gbat_pkg::VAL_W-1:0] value_3;
  logic [3:0]                    value_present;
  modport source(output valid, req_type, group_key, value_0, value_1, value_2, value_3,
                 value_present, input ready);
  modport sink(input valid, req_type, group_key, value_0, value_1, value_2, value_3,
               value_present, output ready);
endinterface

interface gbat_out_if;
  logic                          valid;
  logic                          ready;
  logic [gbat_pkg::KEY_W-1:0]    out_key;
  logic signed [gbat_pkg::SUM_W-1:0] result_0;
  logic signed [gbat_pkg::SUM_W-1:0] result_1;
  logic signed [gbat_pkg::SUM_W-1:0] result_2;
  logic signed [gbat_pkg::SUM_W-1:0] result_3;
  logic                          last;
  logic                          dropped;
  modport source(output valid, out_key, result_0, result_1, result_2, result_3, last,
                 dropped, input ready);
  modport sink(input valid, out_key, result_0, result_1, result_2, result_3, last,
               dropped, output ready);
endinterface

[src/gbat_front.sv]
// front end: accepts beats, classifies them into commands, two-entry queue
// depends on gbat_pkg, gbat_if
module gbat_front (
  input  logic           clk,
  input  logic           rst_n,
  gbat_in_if.sink        in_ch,
  output logic           cmd_valid,
  output gbat_pkg::cmd_t cmd,
  input  logic           cmd_ready
);
  gbat_pkg::cmd_t q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push, pop;
  gbat_pkg::cmd_t cin;

  assign in_ch.ready = (fill_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rd_ptr_r];

  always_comb begin
    cin.is_flush = in_ch.req_type;
    cin.key      = in_ch.group_key;
    cin.val[0]   = in_ch.value_0;
    cin.val[1]   = in_ch.value_1;
    cin.val[2]   = in_ch.value_2;
    cin.val[3]   = in_ch.value_3;
    cin.present  = in_ch.value_present;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cin;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[src/gbat_div.sv]
// iterative signed-by-unsigned divider, one quotient bit a cycle, truncates toward zero
// depends on gbat_pkg
module gbat_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gbat_pkg::SUM_W-1:0] dividend,
  input  logic [gbat_pkg::CNT_W-1:0]        divisor,
  output logic                              done,
  output logic signed [gbat_pkg::SUM_W-1:0] quotient
);
  localparam int STEP_W = $clog2(gbat_pkg::SUM_W);

  logic                        busy_r, done_r, neg_r;
  logic [STEP_W-1:0]           step_r;
  logic [gbat_pkg::CNT_W:0]    rem_r;
  logic [gbat_pkg::SUM_W-1:0]  quo_r;
  logic [gbat_pkg::CNT_W-1:0]  dvs_r;
  logic [gbat_pkg::CNT_W:0]    r_sh;
  logic                        fit;
  logic [gbat_pkg::SUM_W-1:0]  quo_nxt;

  always_comb begin
    r_sh = {rem_r[gbat_pkg::CNT_W-1:0], quo_r[gbat_pkg::SUM_W-1]};
    fit = (r_sh >= {1'b0, dvs_r});
    quo_nxt = {quo_r[gbat_pkg::SUM_W-2:0], fit};
  end

  assign done = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[gbat_pkg::SUM_W-1];
      quo_r <= dividend[gbat_pkg::SUM_W-1] ? -dividend : dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      step_r <= '0;
    end else if (busy_r) begin
      rem_r <= fit ? r_sh - {1'b0, dvs_r} : r_sh;
      quo_r <= quo_nxt;
      step_r <= step_r + 1'b1;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) busy_r <= 1'b1;
      else if (busy_r && step_r == STEP_W'(gbat_pkg::SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end
endmodule

[src/gbat_back.sv]
// back end: key search, accumulator update and flush sequencing with result register
// depends on gbat_pkg, gbat_if, gbat_div
module gbat_back (
  input  logic           clk,
  input  logic           rst_n,
  input  gbat_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  gbat_pkg::cmd_t cmd,
  output logic           cmd_ready,
  gbat_out_if.source     out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_NEW, S_ROWRD, S_UPDATE, S_FLRD, S_SLOT, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  gbat_pkg::cmd_t cmd_r;
  logic [gbat_pkg::KEY_W-1:0] key_mem [gbat_pkg::NUM_GROUPS];
  gbat_pkg::acc_row_t         acc_mem [gbat_pkg::NUM_GROUPS];
  logic [gbat_pkg::KEY_W-1:0] key_q_r;
  gbat_pkg::acc_row_t         acc_q_r;

  logic [gbat_pkg::TOT_W-1:0]  total_r, scan_r;
  logic                        chk_r, fresh_r, drop_r;
  logic [gbat_pkg::GIDX_W-1:0] gi_r, grp_r;
  logic [gbat_pkg::SLOT_W-1:0] slot_r;
  logic signed [gbat_pkg::SUM_W-1:0] res_r [gbat_pkg::MAX_SLOTS];

  logic                        key_rd, acc_rd;
  logic [gbat_pkg::GIDX_W-1:0] key_addr, acc_addr;
  gbat_pkg::acc_row_t          row_nxt;
  logic signed [gbat_pkg::SUM_W-1:0] slot_res;
  logic                        need_div, div_done, grp_last;
  logic signed [gbat_pkg::SUM_W-1:0] div_q;
  logic                        out_free;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign grp_last  = ({1'b0, grp_r} + 1'b1) == total_r;

  always_comb begin
    key_rd = 1'b0;
    acc_rd = 1'b0;
    key_addr = grp_r;
    acc_addr = grp_r;
    case (state_r)
      S_SEARCH: begin
        key_rd = (scan_r != total_r);
        key_addr = scan_r[gbat_pkg::GIDX_W-1:0];
      end
      S_ROWRD: begin
        acc_rd = 1'b1;
        acc_addr = gi_r;
      end
      S_FLRD: begin
        key_rd = 1'b1;
        acc_rd = 1'b1;
      end
      default: ;
    endcase
  end

  // row update over all slots at once
  always_comb begin
    gbat_pkg::slot_acc_t a;
    logic signed [gbat_pkg::SUM_W:0] s;
    logic signed [gbat_pkg::VAL_W-1:0] v;
    logic [2:0] f;
    for (int k = 0; k < gbat_pkg::MAX_SLOTS; k++) begin
      a = fresh_r ? '0 : acc_q_r[k];
      v = $signed(cmd_r.val[k]);
      f = gbat_pkg::slot_func(cfg.funcs, gbat_pkg::SLOT_W'(k));
      s = {a.sum[gbat_pkg::SUM_W-1], a.sum} +
          {{(gbat_pkg::SUM_W + 1 - gbat_pkg::VAL_W){v[gbat_pkg::VAL_W-1]}}, v};
      row_nxt[k] = a;
      if (gbat_pkg::NCNT_W'(k) < cfg.n) begin
        if (f == gbat_pkg::FN_COUNT) begin
          if (a.cnt != '1) row_nxt[k].cnt = a.cnt + 1'b1;
        end else if (cmd_r.present[k]) begin
          if (s[gbat_pkg::SUM_W] != s[gbat_pkg::SUM_W-1])
            row_nxt[k].sum = s[gbat_pkg::SUM_W] ? {1'b1, {(gbat_pkg::SUM_W-1){1'b0}}}
                                                : {1'b0, {(gbat_pkg::SUM_W-1){1'b1}}};
          else
            row_nxt[k].sum = s[gbat_pkg::SUM_W-1:0];
          if (a.cnt == '0 || v < a.mn) row_nxt[k].mn = v;
          if (a.cnt == '0 || v > a.mx) row_nxt[k].mx = v;
          if (a.cnt != '1) row_nxt[k].cnt = a.cnt + 1'b1;
        end
      end
    end
  end

  // result of the current slot, except averages
  always_comb begin
    gbat_pkg::slot_acc_t a;
    logic [2:0] f;
    a = acc_q_r[slot_r];
    f = gbat_pkg::slot_func(cfg.funcs, slot_r);
    slot_res = '0;
    need_div = 1'b0;
    if ({1'b0, slot_r} < cfg.n && a.cnt != '0) begin
      case (f)
        gbat_pkg::FN_SUM: slot_res = a.sum;
        gbat_pkg::FN_AVG: need_div = 1'b1;
        gbat_pkg::FN_MIN: slot_res = gbat_pkg::SUM_W'(a.mn);
        gbat_pkg::FN_MAX: slot_res = gbat_pkg::SUM_W'(a.mx);
        default: slot_res = a.cnt[gbat_pkg::CNT_W-1] ? {1'b0, {(gbat_pkg::SUM_W-1){1'b1}}}
                                                     : {a.cnt, 16'h0};
      endcase
    end
  end

  gbat_div u_div (
    .clk(clk), .rst_n(rst_n),
    .start(state_r == S_SLOT && need_div),
    .dividend(acc_q_r[slot_r].sum),
    .divisor(acc_q_r[slot_r].cnt),
    .done(div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (key_rd) key_q_r <= key_mem[key_addr];
    if (acc_rd) acc_q_r <= acc_mem[acc_addr];
    if (state_r == S_NEW && total_r != gbat_pkg::TOT_W'(gbat_pkg::NUM_GROUPS))
      key_mem[total_r[gbat_pkg::GIDX_W-1:0]] <= cmd_r.key;
    if (state_r == S_UPDATE) acc_mem[gi_r] <= row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      drop_r <= 1'b0;
      out_ch.valid <= 1'b0;
      scan_r <= '0;
      chk_r <= 1'b0;
      fresh_r <= 1'b0;
      grp_r <= '0;
      slot_r <= '0;
      gi_r <= '0;
    end else begin
      // the output state reloads the register itself
      if (out_ch.valid && out_ch.ready && state_r != S_OUT) out_ch.valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            scan_r <= '0;
            chk_r <= 1'b0;
            grp_r <= '0;
            if (cmd.is_flush) state_r <= (total_r == '0) ? S_IDLE : S_FLRD;
            else state_r <= (total_r == '0) ? S_NEW : S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (chk_r && key_q_r == cmd_r.key) begin
            gi_r <= gbat_pkg::GIDX_W'(scan_r - 1'b1);
            state_r <= S_ROWRD;
          end else if (scan_r == total_r) begin
            state_r <= S_NEW;
          end else begin
            scan_r <= scan_r + 1'b1;
            chk_r <= 1'b1;
          end
        end
        S_NEW: begin
          if (total_r == gbat_pkg::TOT_W'(gbat_pkg::NUM_GROUPS)) begin
            drop_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            gi_r <= total_r[gbat_pkg::GIDX_W-1:0];
            total_r <= total_r + 1'b1;
            fresh_r <= 1'b1;
            state_r <= S_UPDATE;
          end
        end
        S_ROWRD: begin
          fresh_r <= 1'b0;
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          fresh_r <= 1'b0;
          state_r <= S_IDLE;
        end
        S_FLRD: begin
          slot_r <= '0;
          state_r <= S_SLOT;
        end
        S_SLOT: begin
          if (need_div) begin
            state_r <= S_DIV;
          end else begin
            res_r[slot_r] <= slot_res;
            if (slot_r == gbat_pkg::SLOT_W'(gbat_pkg::MAX_SLOTS - 1)) state_r <= S_OUT;
            else slot_r <= slot_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_r[slot_r] <= div_q;
            if (slot_r == gbat_pkg::SLOT_W'(gbat_pkg::MAX_SLOTS - 1)) state_r <= S_OUT;
            else begin
              slot_r <= slot_r + 1'b1;
              state_r <= S_SLOT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            out_ch.out_key <= key_q_r;
            out_ch.result_0 <= res_r[0];
            out_ch.result_1 <= res_r[1];
            out_ch.result_2 <= res_r[2];
            out_ch.result_3 <= res_r[3];
            out_ch.last <= grp_last;
            out_ch.dropped <= drop_r;
            grp_r <= grp_r + 1'b1;
            state_r <= grp_last ? S_IDLE : S_FLRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= gbat_pkg::TOT_W'(gbat_pkg::NUM_GROUPS))
    else $error("group count beyond table size");
  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |=> drop_r)
    else $error("drop flag cleared");
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEW && total_r == gbat_pkg::TOT_W'(gbat_pkg::NUM_GROUPS)) |=> drop_r)
    else $error("full table did not flag drop");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd_ready)
    else $error("command taken while busy");
endmodule

[src/group_by_aggregate_table_unit.sv]
// Group-by aggregation table. A row beat searches the stored keys in turn, then reads and
// updates its group's accumulator row, starts a new group, or is dropped on a full table:
// keys sit in a single-port key memory read one entry a cycle. A flush beat emits one
// result beat per group in insertion order; each group waits for the shared one-bit-a-cycle
// divider on an average slot that holds values, and while the result register is held. Up
// to two beats queue ahead of the engine. Configuration is to be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block itself does not enforce it.
module group_by_aggregate_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  gbat_in_if.sink                             in_ch,
  gbat_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [gbat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbat_pkg::CFG_DATA_W-1:0]     cfg_data
);
  logic [gbat_pkg::NCNT_W-1:0]  agg_count_r;
  logic [gbat_pkg::FUNCS_W-1:0] agg_funcs_r;
  gbat_pkg::cfg_t cfg;
  logic           cmd_valid, cmd_ready;
  gbat_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_count_r <= gbat_pkg::NCNT_W'(1);
      agg_funcs_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gbat_pkg::REG_AGG_COUNT: agg_count_r <= cfg_data[gbat_pkg::NCNT_W-1:0];
        gbat_pkg::REG_AGG_FUNCS: agg_funcs_r <= cfg_data[gbat_pkg::FUNCS_W-1:0];
        default: ;
      endcase
    end
  end

  // slot count clamps to the slot array
  always_comb begin
    cfg.n = (agg_count_r > gbat_pkg::NCNT_W'(gbat_pkg::MAX_SLOTS))
            ? gbat_pkg::NCNT_W'(gbat_pkg::MAX_SLOTS) : agg_count_r;
    cfg.funcs = agg_funcs_r;
  end

  gbat_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
  );

  gbat_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready),
    .out_ch(out_ch)
  );
endmodule

[verif/gbat_scoreboard.sv]
`timescale 1ns / 100ps
// checker of the group-by aggregation table: watches the row/flush, result and config ports
// keeps its own copy of the group table, predicts flush results and compares them
// depends on gbat_pkg and the channel interfaces in gbat_if.sv
module gbat_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  gbat_in_if                              in_mon,
  gbat_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [gbat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbat_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [gbat_pkg::KEY_W-1:0]                          key;
    logic [gbat_pkg::MAX_SLOTS-1:0][gbat_pkg::SUM_W-1:0] res;
    logic                                                last;
    logic                                                dropped;
  } group_line_t;

  group_line_t                flush_lines[$];
  logic [gbat_pkg::KEY_W-1:0] grp_key[gbat_pkg::NUM_GROUPS];
  int                         grp_total;
  longint                     grp_sum[gbat_pkg::NUM_GROUPS][gbat_pkg::MAX_SLOTS];
  int                         grp_min[gbat_pkg::NUM_GROUPS][gbat_pkg::MAX_SLOTS];
  int                         grp_max[gbat_pkg::NUM_GROUPS][gbat_pkg::MAX_SLOTS];
  logic [gbat_pkg::CNT_W-1:0] grp_cnt[gbat_pkg::NUM_GROUPS][gbat_pkg::MAX_SLOTS];
  logic                         table_overflow;
  logic [gbat_pkg::NCNT_W-1:0]  slots_cfg;
  logic [gbat_pkg::FUNCS_W-1:0] funcs_cfg;

  function automatic int live_slots();
    return (slots_cfg > gbat_pkg::MAX_SLOTS) ? gbat_pkg::MAX_SLOTS : int'(slots_cfg);
  endfunction

  function automatic logic [2:0] fn_of_slot(int k);
    logic [2:0] f;
    f = funcs_cfg[3*k +: 3];
    return (f > gbat_pkg::FN_MAX) ? gbat_pkg::FN_COUNT : f;
  endfunction

  function automatic longint aggregate_of(int g, int k);
    longint q;
    if (grp_cnt[g][k] == 0) return 0;
    case (fn_of_slot(k))
      gbat_pkg::FN_SUM: return grp_sum[g][k];
      gbat_pkg::FN_AVG: return grp_sum[g][k] / longint'({32'd0, grp_cnt[g][k]});
      gbat_pkg::FN_MIN: return longint'(grp_min[g][k]);
      gbat_pkg::FN_MAX: return longint'(grp_max[g][k]);
      default: begin
        q = longint'({32'd0, grp_cnt[g][k]}) << 16;
        return (q > SAT_HI) ? SAT_HI : q;
      end
    endcase
  endfunction

  task automatic accumulate_row(
      input logic [gbat_pkg::KEY_W-1:0] key,
      input logic [gbat_pkg::MAX_SLOTS-1:0][gbat_pkg::VAL_W-1:0] vals,
      input logic [gbat_pkg::MAX_SLOTS-1:0] present);
    int     gi;
    int     v;
    longint s;
    gi = -1;
    for (int g = 0; g < grp_total; g++)
      if (gi < 0 && grp_key[g] == key) gi = g;
    if (gi < 0) begin
      if (grp_total >= gbat_pkg::NUM_GROUPS) begin
        table_overflow = 1'b1;
        return;
      end
      gi = grp_total++;
      grp_key[gi] = key;
      for (int k = 0; k < gbat_pkg::MAX_SLOTS; k++) begin
        grp_sum[gi][k] = 0;
        grp_min[gi][k] = 0;
        grp_max[gi][k] = 0;
        grp_cnt[gi][k] = '0;
      end
    end
    for (int k = 0; k < live_slots(); k++) begin
      if (fn_of_slot(k) == gbat_pkg::FN_COUNT) begin
        if (grp_cnt[gi][k] != '1) grp_cnt[gi][k]++;
      end else if (present[k]) begin
        v = int'($signed(vals[k]));
        s = grp_sum[gi][k] + longint'(v);
        if (s > SAT_HI) s = SAT_HI;
        if (s < SAT_LO) s = SAT_LO;
        grp_sum[gi][k] = s;
        // first counted value seeds both extremes
        if (grp_cnt[gi][k] == 0) begin
          grp_min[gi][k] = v;
          grp_max[gi][k] = v;
        end else begin
          if (v < grp_min[gi][k]) grp_min[gi][k] = v;
          if (v > grp_max[gi][k]) grp_max[gi][k] = v;
        end
        if (grp_cnt[gi][k] != '1) grp_cnt[gi][k]++;
      end
    end
  endtask

  task automatic predict_flush();
    group_line_t line;
    for (int g = 0; g < grp_total; g++) begin
      line.key = grp_key[g];
      for (int k = 0; k < gbat_pkg::MAX_SLOTS; k++)
        line.res[k] = (k < live_slots()) ? gbat_pkg::SUM_W'(aggregate_of(g, k)) : '0;
      line.last    = (g + 1 == grp_total);
      line.dropped = table_overflow;
      flush_lines.push_back(line);
    end
  endtask

  task automatic check_result();
    group_line_t want, got;
    got.key     = out_mon.out_key;
    got.res     = {out_mon.result_3, out_mon.result_2, out_mon.result_1, out_mon.result_0};
    got.last    = out_mon.last;
    got.dropped = out_mon.dropped;
    if (flush_lines.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result beat key %h", got.key);
      return;
    end
    want = flush_lines.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result mismatch\n  exp key %h res %h %h %h %h last %b drop %b\n"
                 , want.key, want.res[0], want.res[1], want.res[2], want.res[3]
                 , want.last, want.dropped,
                 "  got key %h res %h %h %h %h last %b drop %b",
                 got.key, got.res[0], got.res[1], got.res[2], got.res[3],
                 got.last, got.dropped);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      flush_lines.delete();
      fail_count     = 0;
      grp_total      = 0;
      table_overflow = 1'b0;
      slots_cfg      = 3'd1;
      funcs_cfg      = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gbat_pkg::REG_AGG_COUNT)
          slots_cfg = cfg_data[gbat_pkg::NCNT_W-1:0];
        else if (cfg_index == gbat_pkg::REG_AGG_FUNCS)
          funcs_cfg = cfg_data[gbat_pkg::FUNCS_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type) predict_flush();
        else accumulate_row(in_mon.group_key,
                            {in_mon.value_3, in_mon.value_2, in_mon.value_1, in_mon.value_0},
                            in_mon.value_present);
      end
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending = flush_lines.size();
  end

endmodule

[verif/tb_group_by_aggregate_table_unit.sv]
`timescale 1ns / 100ps
// top of the group-by aggregation table bench: clock, reset, row/flush stimulus, config writes
// depends on gbat_pkg, gbat_if.sv, gbat_scoreboard and group_by_aggregate_table_unit
module tb_group_by_aggregate_table_unit;

  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int SETTLE      = 300;
  localparam logic REQ_ROW   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  logic clk = 1'b0;
  logic rst_n;
  logic                            cfg_we;
  logic [gbat_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gbat_pkg::CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;
  int src_gap_pct, sink_stall_pct;
  int cycle_no;
  logic [gbat_pkg::KEY_W-1:0] key_pool[90];

  always #1 clk = ~clk;

  gbat_in_if  in_ch();
  gbat_out_if out_ch();

  group_by_aggregate_table_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gbat_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_beat(input logic rt, input logic [gbat_pkg::KEY_W-1:0] key,
                           input logic [31:0] v0, v1, v2, v3, input logic [3:0] pres);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= rt;
    in_ch.group_key     <= key;
    in_ch.value_0       <= v0;
    in_ch.value_1       <= v1;
    in_ch.value_2       <= v2;
    in_ch.value_3       <= v3;
    in_ch.value_present <= pres;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic flush_table();
    send_beat(REQ_FLUSH, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom,
              4'($urandom));
  endtask

  // drain every result, then let queued rows finish before touching registers
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gbat_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gbat_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'($urandom_range(200000)) - 32'd100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [gbat_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(89)];
  endfunction

  task automatic random_rows(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(19) == 0) flush_table();
      else send_beat(REQ_ROW, pick_key(), pick_value(), pick_value(), pick_value(),
                     pick_value(), 4'($urandom));
    end
  endtask

  initial begin
    logic [gbat_pkg::KEY_W-1:0] heavy_key;
    int counts[6];
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    src_gap_pct         = 0;
    sink_stall_pct      = 0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_ROW;
    in_ch.group_key     = '0;
    in_ch.value_0       = '0;
    in_ch.value_1       = '0;
    in_ch.value_2       = '0;
    in_ch.value_3       = '0;
    in_ch.value_present = '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    heavy_key   = key_pool[2];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table flush gives nothing
    flush_table();
    drain_and_settle();
    write_reg(gbat_pkg::REG_AGG_COUNT, 12'd4);
    write_reg(gbat_pkg::REG_AGG_FUNCS,
              {3'd0, gbat_pkg::FN_MAX, gbat_pkg::FN_MIN, gbat_pkg::FN_AVG, gbat_pkg::FN_SUM});

    // short run on one group at the value extremes in both directions
    for (int i = 0; i < 6; i++)
      send_beat(REQ_ROW, heavy_key, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 4'hF);
    flush_table();
    send_beat(REQ_ROW, '0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 4'h0);
    send_beat(REQ_ROW, '0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 4'b0101);
    send_beat(REQ_ROW, '1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h1, 4'b1010);
    send_beat(REQ_ROW, '1, 32'h7FFF_FFFF, 32'h0000_0003, 32'h7FFF_FFFF, 32'h8000_0000, 4'hF);
    send_beat(REQ_ROW, '1, 32'hFFFF_FFFD, 32'hFFFF_FFF9, 32'h8000_0000, 32'h7FFF_FFFF, 4'hF);
    send_beat(REQ_ROW, key_pool[3], 32'h1, 32'hFFFF_FFFF, 32'h5, 32'h5, 4'b0011);
    flush_table();
    drain_and_settle();
    // too many slots, count codes including the ones above max
    write_reg(gbat_pkg::REG_AGG_COUNT, 12'd7);
    write_reg(gbat_pkg::REG_AGG_FUNCS, {3'd7, 3'd5, gbat_pkg::FN_COUNT, 3'd6});
    send_beat(REQ_ROW, key_pool[3], 32'h1, 32'h2, 32'h3, 32'h4, 4'h0);
    send_beat(REQ_ROW, '1, 32'h1, 32'h2, 32'h3, 32'h4, 4'hF);
    flush_table();
    drain_and_settle();
    write_reg(gbat_pkg::REG_AGG_COUNT, 12'd0);
    send_beat(REQ_ROW, '0, 32'h1, 32'h2, 32'h3, 32'h4, 4'hF);
    flush_table();
    drain_and_settle();

    // random rows in six stretches, each under new settings; the idle profile changes every two stretches
    counts = '{4, 2, 7, 0, 3, 4};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gbat_pkg::REG_AGG_COUNT, 12'(counts[ph]));
      case (ph)
        1: write_reg(gbat_pkg::REG_AGG_FUNCS, 12'hFFF);
        3: write_reg(gbat_pkg::REG_AGG_FUNCS, {gbat_pkg::FN_AVG, gbat_pkg::FN_AVG,
                                               gbat_pkg::FN_AVG, gbat_pkg::FN_AVG});
        default: write_reg(gbat_pkg::REG_AGG_FUNCS, 12'($urandom));
      endcase
      src_gap_pct    = (ph < 2) ? 35 : (ph < 4) ? 79 : 0;
      sink_stall_pct = (ph < 2) ? 79 : (ph < 4) ? 35 : 0;
      random_rows(64);
      // funcs changed under live accumulators before this flush
      if (ph == 2) begin
        drain_and_settle();
        write_reg(gbat_pkg::REG_AGG_FUNCS, 12'($urandom));
      end
      flush_table();
      drain_and_settle();
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
src/gbat_pkg.sv
src/gbat_if.sv
src/gbat_front.sv
src/gbat_div.sv
src/gbat_back.sv
src/group_by_aggregate_table_unit.sv
verif/gbat_scoreboard.sv
verif/tb_group_by_aggregate_table_unit.sv
